// ----- rtl/core/tapered_mix_accumulate_assert.svh -----
// ----------------------------------------------------------------------------
// tapered_mix_accumulate_assert.svh
// Assertion macros for the mix accumulator; compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef TAPERED_MIX_ACCUMULATE_ASSERT_SVH
`define TAPERED_MIX_ACCUMULATE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define TMA_ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("tma assertion failed");
// next-cycle implication
`define TMA_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("tma assertion failed");
`else
`define TMA_ASSERT_SAME(label, clk, rst_n, a, b)
`define TMA_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ----- rtl/core/tma_pkg.sv -----
// ----------------------------------------------------------------------------
// tma_pkg
// Types and constants shared by the mix accumulator modules.
// ----------------------------------------------------------------------------
`default_nettype none
package tma_pkg;

    localparam int unsigned TMA_BUFFER_DEPTH = 65536;
    localparam int unsigned CMD_ADDR_W       = 17;
    localparam int unsigned CFG_IDX_W        = 3;
    localparam int unsigned CFG_DATA_W       = 17;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAPER  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SUB    = 3'd4;

    typedef enum logic [1:0] {OP_MIX, OP_READ, OP_WRITE} t_op;
    typedef enum logic [1:0] {ST_OK, ST_RANGE, ST_SAT} t_status;
    typedef enum logic [1:0] {K_MIX, K_READ, K_WRITE, K_FLAG} t_kind;

    typedef struct packed {
        logic [1:0]         op;
        logic [15:0]        address;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic signed [31:0] data;
        logic [1:0]         status;
        logic               pass_done;
    } t_out;

    typedef struct packed {
        logic [15:0] start_offset;
        logic [16:0] mix_length;
        logic [15:0] taper_length;
        logic [15:0] mix_level;
        logic        subtract_mode;
    } t_cfg;

    // classified word passed from front to back
    typedef struct packed {
        t_kind                  kind;
        logic [CMD_ADDR_W-1:0]  addr;
        logic signed [31:0]     value;
        logic [15:0]            tden;
        logic [15:0]            tnum;
        logic                   unity;
        logic                   done;
    } t_cmd;

    // back status seen by the top level
    typedef struct packed {
        logic clearing;
        logic out_load;
    } t_back_stat;

endpackage
`default_nettype wire

// ----- rtl/core/tma_ram.sv -----
// ----------------------------------------------------------------------------
// tma_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module tma_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/core/tma_queue.sv -----
// ----------------------------------------------------------------------------
// tma_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module tma_queue import tma_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output t_cmd      o_cmd,
    output logic      o_empty
);
    localparam int unsigned QD = 2;
    localparam int unsigned PW = $clog2(QD);

    t_cmd              r_q [QD];
    logic [PW-1:0]     r_wp, r_rp;
    logic [PW:0]       r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(QD));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_q[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/tma_front.sv -----
// ----------------------------------------------------------------------------
// tma_front
// Accepts words, tracks pass position and frame count, classifies each
// word and computes its fade ramp terms.
// ----------------------------------------------------------------------------
`default_nettype none
module tma_front import tma_pkg::*; #(
    parameter int unsigned BUFFER_DEPTH = TMA_BUFFER_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_cfg      i_cfg,
    input  wire logic i_clearing,
    input  wire logic i_push,
    input  t_in       i_in,
    output logic      o_full,
    output logic      o_q_push,
    output t_cmd      o_q_cmd,
    input  wire logic i_q_full
);
    localparam logic [31:0] DEPTH_W = 32'(BUFFER_DEPTH);

    logic [16:0] r_sample_index, r_frame_count;
    logic        r_s1_valid;
    logic [1:0]  r_s1_op;
    logic [15:0] r_s1_addr;
    logic signed [31:0] r_s1_val;
    logic [16:0] r_s1_i;
    logic [15:0] r_s1_t, r_s1_half;
    logic        r_s1_done;

    logic        accept;
    logic [16:0] n, i_cur;
    logic [17:0] i_inc;
    logic        done;
    logic [15:0] half, t;

    // stage 1: pass position and clamped taper
    always_comb begin
        accept = i_push && !o_full;
        n      = (i_cfg.mix_length == '0) ? 17'd1 : i_cfg.mix_length;
        i_cur  = (r_sample_index >= n) ? '0 : r_sample_index;
        i_inc  = {1'b0, i_cur} + 18'd1;
        done   = (i_inc >= {1'b0, n});
        half   = n[16:1];
        if ({i_cfg.taper_length, 1'b0} > n) begin
            t = (half >= 16'd3) ? half - 16'd1 : 16'd1;
        end else begin
            t = i_cfg.taper_length;
        end
    end

    logic [16:0] d, pos, fc_sum, fc;
    logic signed [18:0] e_raw;
    logic [15:0] e;
    logic        rng_bad;

    // stage 2: ramp position, range checks, classification
    always_comb begin
        d = (r_s1_i >= {1'b0, r_s1_half}) ? r_s1_i - {1'b0, r_s1_half}
                                           : {1'b0, r_s1_half} - r_s1_i;
        e_raw = $signed({2'b0, d}) + $signed({3'b0, r_s1_t})
              - $signed({3'b0, r_s1_half});
        if (e_raw < 0)                             e = '0;
        else if (e_raw > $signed({3'b0, r_s1_t})) e = r_s1_t;
        else                                       e = e_raw[15:0];
        pos    = {1'b0, i_cfg.start_offset} + r_s1_i;
        fc_sum = {1'b0, i_cfg.start_offset} + i_cfg.mix_length
               + {16'd0, (i_cfg.mix_length == '0)};
        fc     = (32'(fc_sum) > DEPTH_W) ? 17'(BUFFER_DEPTH) : fc_sum;
        rng_bad = ({1'b0, r_s1_addr} >= r_frame_count) || (32'(r_s1_addr) >= DEPTH_W);

        o_q_push      = r_s1_valid && !i_q_full;
        o_q_cmd.value = r_s1_val;
        o_q_cmd.tden  = r_s1_t;
        o_q_cmd.tnum  = r_s1_t - e;
        o_q_cmd.unity = (r_s1_t == '0) || (e == '0);
        o_q_cmd.done  = 1'b0;
        o_q_cmd.addr  = {1'b0, r_s1_addr};
        case (r_s1_op)
            OP_MIX: begin
                o_q_cmd.done = r_s1_done;
                o_q_cmd.addr = pos;
                o_q_cmd.kind = (32'(pos) >= DEPTH_W) ? K_FLAG : K_MIX;
            end
            OP_READ:  o_q_cmd.kind = rng_bad ? K_FLAG : K_READ;
            OP_WRITE: o_q_cmd.kind = rng_bad ? K_FLAG : K_WRITE;
            default:  o_q_cmd.kind = K_FLAG;
        endcase
    end

    assign o_full = i_clearing || (r_s1_valid && i_q_full);

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op   <= i_in.op;
            r_s1_addr <= i_in.address;
            r_s1_val  <= i_in.value;
            r_s1_i    <= i_cur;
            r_s1_t    <= t;
            r_s1_half <= half;
            r_s1_done <= done;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid     <= 1'b0;
            r_sample_index <= '0;
            r_frame_count  <= '0;
        end else begin
            if (accept)        r_s1_valid <= 1'b1;
            else if (o_q_push) r_s1_valid <= 1'b0;
            if (accept && i_in.op == OP_MIX) begin
                r_sample_index <= done ? '0 : i_inc[16:0];
            end
            // frame count grows at the first sample of a pass
            if (o_q_push && r_s1_op == OP_MIX && r_s1_i == '0 && fc > r_frame_count) begin
                r_frame_count <= fc;
            end
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/tma_back.sv -----
// ----------------------------------------------------------------------------
// tma_back
// Executes queued words against the mix buffer: fade divide, gain multiply,
// saturating accumulate, entry read and write, plus the reset clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module tma_back import tma_pkg::*; #(
    parameter int unsigned BUFFER_DEPTH = TMA_BUFFER_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_cfg      i_cfg,
    input  t_cmd      i_cmd,
    input  wire logic i_q_empty,
    output logic      o_q_pop,
    output t_out      o_out,
    output logic      o_empty,
    input  wire logic i_pop,
    output t_back_stat o_stat
);
    localparam int unsigned AW = $clog2(BUFFER_DEPTH);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD1, S_RD2, S_DIV, S_MUL1, S_MUL2, S_MUL3, S_ACC, S_APPLY
    } t_state;

    t_state       r_state;
    logic [AW-1:0] r_clr_addr, r_raddr;
    t_cmd         r_cmd;
    logic [16:0]  r_rem;
    logic [15:0]  r_quo;
    logic [3:0]   r_cnt;
    logic [31:0]  r_mag;
    logic [32:0]  r_p1;
    logic [48:0]  r_pl;
    logic [47:0]  r_ph;
    logic [36:0]  r_term;
    logic         r_out_valid;
    t_out         r_out;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata, ram_rdata;
    logic [20:0]   cmd_addr_w;
    logic [16:0]   rem2;
    logic          out_free, load;
    t_out          res;
    logic signed [37:0] term;
    logic signed [38:0] sum;
    logic signed [31:0] sat;
    logic          sat_hit;
    logic [16:0]   env;

    tma_ram #(.WIDTH(32), .DEPTH(BUFFER_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_raddr),
        .o_rdata (ram_rdata)
    );

    // entry plus or minus the scaled term, widened
    function automatic logic signed [38:0] r_cfg_sub_ext(
        input logic [31:0] entry, input logic signed [37:0] tm, input logic sub);
        logic signed [38:0] ev;
        ev = 39'($signed(entry));
        return sub ? ev - 39'(tm) : ev + 39'(tm);
    endfunction

    // datapath and handshake decode
    always_comb begin
        out_free   = !r_out_valid || i_pop;
        cmd_addr_w = 21'(i_cmd.addr);
        rem2       = {r_rem[15:0], 1'b0};
        env        = r_cmd.unity ? 17'h10000 : {1'b0, r_quo};
        term       = r_cmd.value[31] ? -$signed({1'b0, r_term}) : $signed({1'b0, r_term});
        sum        = r_cfg_sub_ext(ram_rdata, term, i_cfg.subtract_mode);
        sat_hit    = 1'b0;
        if (sum > 39'sd2147483647) begin
            sat = 32'sh7FFFFFFF; sat_hit = 1'b1;
        end else if (sum < -39'sd2147483648) begin
            sat = 32'sh80000000; sat_hit = 1'b1;
        end else begin
            sat = sum[31:0];
        end

        o_q_pop   = 1'b0;
        load      = 1'b0;
        res       = '{data: '0, status: ST_OK, pass_done: 1'b0};
        ram_we    = 1'b0;
        ram_waddr = cmd_addr_w[AW-1:0];
        ram_wdata = i_cmd.value;
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
            end
            S_IDLE: begin
                if (!i_q_empty) begin
                    case (i_cmd.kind)
                        K_MIX, K_READ: o_q_pop = 1'b1;
                        K_WRITE: begin
                            o_q_pop = out_free;
                            load    = out_free;
                            ram_we  = out_free;
                            res.data = i_cmd.value;
                        end
                        default: begin
                            o_q_pop = out_free;
                            load    = out_free;
                            res.status    = ST_RANGE;
                            res.pass_done = i_cmd.done;
                        end
                    endcase
                end
            end
            S_RD2: begin
                load     = out_free;
                res.data = {{16{ram_rdata[15]}}, ram_rdata[15:0]};
            end
            S_APPLY: begin
                load      = out_free;
                ram_we    = out_free;
                ram_waddr = r_raddr;
                ram_wdata = sat;
                res.data      = sat;
                res.status    = sat_hit ? ST_SAT : ST_OK;
                res.pass_done = r_cmd.done;
            end
            default: ;
        endcase
    end

    assign o_out   = r_out;
    assign o_empty = !r_out_valid;
    assign o_stat  = '{clearing: (r_state == S_CLEAR), out_load: load};

    // sequencer, datapath registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load)       r_out_valid <= 1'b1;
            else if (i_pop) r_out_valid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(BUFFER_DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (o_q_pop) begin
                        r_cmd   <= i_cmd;
                        r_raddr <= cmd_addr_w[AW-1:0];
                        r_rem   <= {1'b0, i_cmd.tnum};
                        r_cnt   <= '0;
                        if (i_cmd.kind == K_READ)  r_state <= S_RD1;
                        else if (i_cmd.kind == K_MIX) r_state <= i_cmd.unity ? S_MUL1 : S_DIV;
                    end
                end
                S_RD1: r_state <= S_RD2;
                S_RD2: if (out_free) r_state <= S_IDLE;
                S_DIV: begin
                    // one quotient bit per cycle
                    if (rem2 >= {1'b0, r_cmd.tden}) begin
                        r_rem <= rem2 - {1'b0, r_cmd.tden};
                        r_quo <= {r_quo[14:0], 1'b1};
                    end else begin
                        r_rem <= rem2;
                        r_quo <= {r_quo[14:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 4'd15) r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_p1  <= i_cfg.mix_level * env;
                    r_mag <= r_cmd.value[31] ? 32'(-r_cmd.value) : r_cmd.value;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_pl    <= r_mag * r_p1[16:0];
                    r_state <= S_MUL3;
                end
                S_MUL3: begin
                    r_ph    <= r_mag * r_p1[32:17];
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_term  <= 37'((65'(r_pl) + (65'(r_ph) << 17)) >> 28);
                    r_state <= S_APPLY;
                end
                S_APPLY: if (out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
        if (load) r_out <= res;
    end
endmodule
`default_nettype wire

// ----- rtl/core/tapered_mix_accumulate.sv -----
// Words pass the front stages and the queue; writes and flagged words finish
// in idle, reads via RD1 and RD2, mixes via DIV (not at unity fade) to APPLY.
// Throughput: one word per back-end pass; the 16-step fade divider bounds mix.
// Reset (synchronous, active low) clears control and runs a clearing pass over
// all BUFFER_DEPTH entries of the mix buffer with full held high.
// ----------------------------------------------------------------------------
// tapered_mix_accumulate
// Mix buffer with gain, trapezoid fade and saturating accumulate.
// ----------------------------------------------------------------------------
`default_nettype none
`include "tapered_mix_accumulate_assert.svh"
module tapered_mix_accumulate import tma_pkg::*; #(
    parameter int unsigned BUFFER_DEPTH = TMA_BUFFER_DEPTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_push,
    input  t_in                        i_in,
    output logic                       o_full,
    input  wire logic                  i_pop,
    output t_out                       o_out,
    output logic                       o_empty
);
    t_cfg       r_cfg;
    t_cmd       q_in_cmd, q_out_cmd;
    logic       q_push, q_full, q_pop, q_empty;
    t_back_stat stat;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{start_offset: '0, mix_length: 17'd1, taper_length: '0,
                       mix_level: 16'd4096, subtract_mode: 1'b0};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_START:  r_cfg.start_offset  <= i_cfg_data[15:0];
                REG_LENGTH: r_cfg.mix_length    <= i_cfg_data;
                REG_TAPER:  r_cfg.taper_length  <= i_cfg_data[15:0];
                REG_LEVEL:  r_cfg.mix_level     <= i_cfg_data[15:0];
                REG_SUB:    r_cfg.subtract_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    tma_front #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_clearing (stat.clearing),
        .i_push     (i_push),
        .i_in       (i_in),
        .o_full     (o_full),
        .o_q_push   (q_push),
        .o_q_cmd    (q_in_cmd),
        .i_q_full   (q_full)
    );

    tma_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (q_out_cmd),
        .o_empty (q_empty)
    );

    tma_back #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_cmd     (q_out_cmd),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .o_out     (o_out),
        .o_empty   (o_empty),
        .i_pop     (i_pop),
        .o_stat    (stat)
    );

    // no word enters while the buffer is being cleared
    `TMA_ASSERT_SAME(a_clear_blocks_input, i_clk, i_rst_n, stat.clearing, o_full)
    // a taken result with nothing new behind it leaves the output empty
    `TMA_ASSERT_NEXT(a_pop_drains, i_clk, i_rst_n, i_pop && !o_empty && !stat.out_load, o_empty)
    // the back never pulls from an empty queue
    `TMA_ASSERT_SAME(a_no_pop_empty, i_clk, i_rst_n, q_pop, !q_empty)
endmodule
`default_nettype wire
